### src/esv_pkg.sv
package esv_pkg;

    // Fixed-point arithmetic width, Q16.16
    localparam int ARITH_W        = 32;
    localparam int COORD_WIDTH_DEF = 32;

    // Configuration registers
    localparam int TS_W       = 31;
    localparam int FS_W       = 17;
    localparam int CFG_DATA_W = 31;

    localparam logic [TS_W-1:0] TOP_SPEED_RST  = 31'd65536;
    localparam logic [FS_W-1:0] FRAME_STEP_RST = 17'd1092;

    typedef enum logic [0:0] {
        REG_TOP_SPEED  = 1'b0,
        REG_FRAME_STEP = 1'b1
    } cfg_index_t;

    // Vector length unit
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 64;
    localparam int NORM_W  = 31;

    // Operand widths along the datapath
    localparam int D_MAG_W = 33;     // chaser - agent position
    localparam int W_W     = 50;     // flee vector
    localparam int NV_W    = 36;     // blended velocity
    localparam int QS_W    = 31;     // scaled component magnitude
    localparam int PROD_W  = 62;     // normalized magnitude times top speed

    typedef logic [ARITH_W-1:0] fix_t;

    typedef struct packed {
        fix_t [2:0] cp;
        fix_t [2:0] cv;
        fix_t [2:0] ap;
        fix_t [2:0] av;
    } kin_t;

endpackage

### src/esv_isqrt.sv
module esv_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [esv_pkg::RAD_W-1:0]  radicand,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [esv_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          out_side
);
    import esv_pkg::*;

    localparam int STEPS = ROOT_W;

    logic [RAD_W-1:0]  x_reg    [STEPS];
    logic [RAD_W-1:0]  r_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic              vld_reg  [STEPS];

    // One result bit per stage, bit weight walks down by powers of four
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BITW = RAD_W'(1) << (RAD_W - 2 - 2 * k);

        logic [RAD_W-1:0]  x_in;
        logic [RAD_W-1:0]  r_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [RAD_W-1:0]  x_next;
        logic [RAD_W-1:0]  r_next;

        if (k == 0) begin : g_first
            assign x_in    = radicand;
            assign r_in    = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_rest
            assign x_in    = x_reg[k-1];
            assign r_in    = r_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            if (x_in >= r_in + BITW)
            begin
                x_next = x_in - (r_in + BITW);
                r_next = (r_in >> 1) + BITW;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= x_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = r_reg[STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

### src/esv_div.sv
module esv_div #(
    parameter int DVD_W  = 50,
    parameter int DVS_W  = 31,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quotient,
    output logic [SIDE_W-1:0] out_side
);
    import esv_pkg::*;

    // Restoring division, one quotient bit per stage, MSB first.
    // Caller guarantees dividend < divisor << Q_W.
    logic [DVD_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [DVS_W-1:0]  dvs_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic              vld_reg  [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        localparam int K = Q_W - 1 - i;

        logic [DVD_W-1:0]  rem_in;
        logic [Q_W-1:0]    quo_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic [DVD_W-1:0]  hi;
        logic [DVD_W-1:0]  rem_next;
        logic [Q_W-1:0]    quo_next;

        if (i == 0) begin : g_first
            assign rem_in  = dividend;
            assign quo_in  = '0;
            assign dvs_in  = divisor;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign dvs_in  = dvs_reg[i-1];
            assign side_in = side_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        always_comb
        begin
            hi = rem_in >> K;
            if (hi >= DVD_W'(dvs_in))
            begin
                rem_next = rem_in - (DVD_W'(dvs_in) << K);
                quo_next = quo_in | (Q_W'(1) << K);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                quo_reg[i]  <= quo_next;
                dvs_reg[i]  <= dvs_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quotient  = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

### src/esv_vlen.sv
module esv_vlen #(
    parameter int MAG_W  = 33,
    parameter int SIDE_W = 1,
    parameter int S_W    = $clog2(MAG_W - 30)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][MAG_W-1:0]               mag,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic [S_W-1:0]                      s,
    output logic [esv_pkg::ROOT_W-1:0]          ms,
    output logic [2:0][esv_pkg::NORM_W-1:0]     amag,
    output logic [SIDE_W-1:0]                   out_side
);
    import esv_pkg::*;

    localparam int INNER_W = SIDE_W + 3 * NORM_W + S_W;

    // stage A: largest magnitude and normalizing shift
    logic [MAG_W-1:0]        mx;
    logic [S_W-1:0]          s_next;
    logic [2:0][MAG_W-1:0]   a_mag_reg;
    logic [S_W-1:0]          a_s_reg;
    logic [SIDE_W-1:0]       a_side_reg;
    logic                    a_vld_reg;

    always_comb
    begin
        mx = mag[0];
        if (mag[1] > mx)
            mx = mag[1];
        if (mag[2] > mx)
            mx = mag[2];
        s_next = '0;
        for (int i = NORM_W; i < MAG_W; i++)
        begin
            if (mx[i])
                s_next = S_W'(i - NORM_W + 1);
        end
    end

    // stage B: shift down
    logic [2:0][NORM_W-1:0]  b_next;
    logic [2:0][NORM_W-1:0]  b_a_reg;
    logic [S_W-1:0]          b_s_reg;
    logic [SIDE_W-1:0]       b_side_reg;
    logic                    b_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            b_next[i] = NORM_W'(a_mag_reg[i] >> a_s_reg);
    end

    // stage C: squares
    logic [2:0][2*NORM_W-1:0] c_sq_reg;
    logic [2:0][NORM_W-1:0]   c_a_reg;
    logic [S_W-1:0]           c_s_reg;
    logic [SIDE_W-1:0]        c_side_reg;
    logic                     c_vld_reg;

    // stage D: sum of squares
    logic [RAD_W-1:0]         d_sum_reg;
    logic [2:0][NORM_W-1:0]   d_a_reg;
    logic [S_W-1:0]           d_s_reg;
    logic [SIDE_W-1:0]        d_side_reg;
    logic                     d_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= mag;
            a_s_reg    <= s_next;
            a_side_reg <= in_side;

            b_a_reg    <= b_next;
            b_s_reg    <= a_s_reg;
            b_side_reg <= a_side_reg;

            for (int i = 0; i < 3; i++)
                c_sq_reg[i] <= (2*NORM_W)'(b_a_reg[i]) * (2*NORM_W)'(b_a_reg[i]);
            c_a_reg    <= b_a_reg;
            c_s_reg    <= b_s_reg;
            c_side_reg <= b_side_reg;

            d_sum_reg  <= RAD_W'(c_sq_reg[0]) + RAD_W'(c_sq_reg[1]) + RAD_W'(c_sq_reg[2]);
            d_a_reg    <= c_a_reg;
            d_s_reg    <= c_s_reg;
            d_side_reg <= c_side_reg;
        end
    end

    logic [INNER_W-1:0] root_side;

    esv_isqrt #(
        .SIDE_W (INNER_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_vld_reg),
        .radicand  (d_sum_reg),
        .in_side   ({d_side_reg, d_a_reg, d_s_reg}),
        .out_valid (out_valid),
        .root      (ms),
        .out_side  (root_side)
    );

    assign {out_side, amag, s} = root_side;

endmodule

### src/esv_scale.sv
module esv_scale #(
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [2:0][esv_pkg::NORM_W-1:0] amag,
    input  logic [2:0]                      neg,
    input  logic [esv_pkg::ROOT_W-1:0]      ms,
    input  logic [esv_pkg::TS_W-1:0]        top_speed,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic [2:0][esv_pkg::ARITH_W-1:0] val,
    output logic [SIDE_W-1:0]               out_side
);
    import esv_pkg::*;

    // Each component: sign * floor(amag * top_speed / ms); ms of zero
    // only comes with zero magnitudes, so dividing by one gives zero.
    logic [2:0][PROD_W-1:0] p_reg;
    logic [ROOT_W-1:0]      dvs_reg;
    logic [2:0]             neg_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic                   vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                p_reg[i] <= PROD_W'(amag[i]) * PROD_W'(top_speed);
            dvs_reg  <= (ms == '0) ? ROOT_W'(1) : ms;
            neg_reg  <= neg;
            side_reg <= in_side;
        end
    end

    logic [2:0][QS_W-1:0] q;
    logic [2:0]           q_neg;
    logic [SIDE_W-1:0]    lane_side;

    esv_div #(
        .DVD_W  (PROD_W),
        .DVS_W  (ROOT_W),
        .Q_W    (QS_W),
        .SIDE_W (SIDE_W + 1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg),
        .dividend  (p_reg[0]),
        .divisor   (dvs_reg),
        .in_side   ({side_reg, neg_reg[0]}),
        .out_valid (out_valid),
        .quotient  (q[0]),
        .out_side  ({lane_side, q_neg[0]})
    );

    for (genvar i = 1; i < 3; i++) begin : g_lane
        esv_div #(
            .DVD_W  (PROD_W),
            .DVS_W  (ROOT_W),
            .Q_W    (QS_W),
            .SIDE_W (1)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld_reg),
            .dividend  (p_reg[i]),
            .divisor   (dvs_reg),
            .in_side   (neg_reg[i]),
            .out_valid (),
            .quotient  (q[i]),
            .out_side  (q_neg[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            val[i] = q_neg[i] ? ARITH_W'(-{1'b0, q[i]}) : ARITH_W'({1'b0, q[i]});
    end

    assign out_side = lane_side;

endmodule

### src/evade_steering_velocity.sv
// Evade steering, Q16.16.
// Throughput: one beat per cycle; a stalled output holds the whole pipeline.
// Depth is set by the three 32-step square root units and the three divider
// banks (one 32-step, two 31-step) in series.
// Reset: asynchronous, active low; clears all valid bits, top_speed to 1.0
// and frame_step to 1092.
module evade_steering_velocity #(
    parameter int COORD_WIDTH = esv_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_we,
    input  esv_pkg::cfg_index_t               cfg_index,
    input  logic [esv_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     chaser_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     chaser_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     chaser_pos_z,
    input  logic signed [COORD_WIDTH-1:0]     chaser_vel_x,
    input  logic signed [COORD_WIDTH-1:0]     chaser_vel_y,
    input  logic signed [COORD_WIDTH-1:0]     chaser_vel_z,
    input  logic signed [COORD_WIDTH-1:0]     agent_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     agent_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     agent_pos_z,
    input  logic signed [COORD_WIDTH-1:0]     agent_vel_x,
    input  logic signed [COORD_WIDTH-1:0]     agent_vel_y,
    input  logic signed [COORD_WIDTH-1:0]     agent_vel_z,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_WIDTH-1:0]     new_vel_x,
    output logic signed [COORD_WIDTH-1:0]     new_vel_y,
    output logic signed [COORD_WIDTH-1:0]     new_vel_z
);
    import esv_pkg::*;

    localparam int OUT_W  = (COORD_WIDTH > ARITH_W) ? ARITH_W : COORD_WIDTH;
    localparam logic signed [63:0] OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_LO = -OUT_HI - 64'sd1;

    localparam int S1_W   = $clog2(D_MAG_W - 30);
    localparam int S2_W   = $clog2(W_W - 30);
    localparam int S3_W   = $clog2(NV_W - 30);
    localparam int LEN1_W = ROOT_W + D_MAG_W - NORM_W;
    localparam int LEN3_W = ROOT_W + NV_W - NORM_W;
    localparam int T_W    = 32;
    localparam int TDVD_W = LEN1_W + 16;
    localparam int KIN_W  = $bits(kin_t);

    function automatic fix_t load_in(input logic signed [COORD_WIDTH-1:0] raw);
        logic signed [63:0] v;
        v = 64'(raw);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // ---------------- configuration ----------------
    logic [TS_W-1:0] top_speed_reg;
    logic [FS_W-1:0] frame_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_speed_reg  <= TOP_SPEED_RST;
            frame_step_reg <= FRAME_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP_SPEED:  top_speed_reg  <= cfg_data[TS_W-1:0];
                REG_FRAME_STEP: frame_step_reg <= cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline advances unless a result beat is stuck at the output
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 0: load, position difference ----------------
    kin_t                    kin_in;
    logic signed [32:0]      dd [3];
    logic [2:0][D_MAG_W-1:0] dmag_next;
    kin_t                    s0_kin_reg;
    logic [2:0][D_MAG_W-1:0] s0_dmag_reg;
    logic                    s0_vld_reg;

    always_comb
    begin
        kin_in.cp[0] = load_in(chaser_pos_x);
        kin_in.cp[1] = load_in(chaser_pos_y);
        kin_in.cp[2] = load_in(chaser_pos_z);
        kin_in.cv[0] = load_in(chaser_vel_x);
        kin_in.cv[1] = load_in(chaser_vel_y);
        kin_in.cv[2] = load_in(chaser_vel_z);
        kin_in.ap[0] = load_in(agent_pos_x);
        kin_in.ap[1] = load_in(agent_pos_y);
        kin_in.ap[2] = load_in(agent_pos_z);
        kin_in.av[0] = load_in(agent_vel_x);
        kin_in.av[1] = load_in(agent_vel_y);
        kin_in.av[2] = load_in(agent_vel_z);
        for (int i = 0; i < 3; i++)
        begin
            dd[i] = $signed({kin_in.cp[i][31], kin_in.cp[i]})
                  - $signed({kin_in.ap[i][31], kin_in.ap[i]});
            dmag_next[i] = dd[i][32] ? D_MAG_W'(-dd[i]) : D_MAG_W'(dd[i]);
        end
    end

    // ---------------- distance to chaser ----------------
    logic                 v1_vld;
    logic [S1_W-1:0]      v1_s;
    logic [ROOT_W-1:0]    v1_ms;
    logic [KIN_W-1:0]     v1_side;
    kin_t                 v1_kin;

    esv_vlen #(
        .MAG_W  (D_MAG_W),
        .SIDE_W (KIN_W),
        .S_W    (S1_W)
    ) u_vlen_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_vld_reg),
        .mag       (s0_dmag_reg),
        .in_side   (s0_kin_reg),
        .out_valid (v1_vld),
        .s         (v1_s),
        .ms        (v1_ms),
        .amag      (),
        .out_side  (v1_side)
    );

    assign v1_kin = kin_t'(v1_side);

    // ---------------- lookahead time prep ----------------
    logic [LEN1_W-1:0] len1;
    logic              sat_next;
    logic [TDVD_W-1:0] t_dvd_reg;
    logic              t_sat_reg;
    kin_t              t_kin_reg;
    logic              t_vld_reg;

    always_comb
    begin
        len1     = LEN1_W'(v1_ms) << v1_s;
        // quotient would not fit 32 bits (also covers top speed of zero)
        sat_next = (TS_W + 16)'(len1) >= {top_speed_reg, 16'b0};
    end

    logic [T_W-1:0]   q1;
    logic [KIN_W:0]   d1_side;
    logic             d1_vld;
    kin_t             d1_kin;
    logic             d1_sat;

    esv_div #(
        .DVD_W  (TDVD_W),
        .DVS_W  (TS_W),
        .Q_W    (T_W),
        .SIDE_W (KIN_W + 1)
    ) u_div_look (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_vld_reg),
        .dividend  (t_dvd_reg),
        .divisor   (top_speed_reg),
        .in_side   ({t_kin_reg, t_sat_reg}),
        .out_valid (d1_vld),
        .quotient  (q1),
        .out_side  (d1_side)
    );

    assign d1_kin = kin_t'(d1_side[KIN_W:1]);
    assign d1_sat = d1_side[0];

    // ---------------- chaser velocity times lookahead ----------------
    logic [T_W-1:0]     t_val;
    logic [31:0]        cvm [3];
    logic [2:0][63:0]   m_p_reg;
    kin_t               m_kin_reg;
    logic               m_vld_reg;

    always_comb
    begin
        t_val = d1_sat ? '1 : q1;
        for (int i = 0; i < 3; i++)
            cvm[i] = d1_kin.cv[i][31] ? (~d1_kin.cv[i] + 32'd1) : d1_kin.cv[i];
    end

    // ---------------- flee vector ----------------
    logic [47:0]           mm1   [3];
    logic signed [W_W-1:0] term1 [3];
    logic signed [W_W-1:0] wv    [3];
    logic [2:0][W_W-1:0]   wmag_next;
    logic [2:0]            wneg_next;
    logic [2:0][W_W-1:0]   w_mag_reg;
    logic [2:0]            w_neg_reg;
    fix_t [2:0]            w_av_reg;
    logic                  w_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mm1[i]   = m_p_reg[i][63:16];
            term1[i] = m_kin_reg.cv[i][31] ? -$signed({2'b0, mm1[i]})
                                           :  $signed({2'b0, mm1[i]});
            wv[i]    = W_W'($signed(m_kin_reg.ap[i])) - W_W'($signed(m_kin_reg.cp[i]))
                     - term1[i];
            wneg_next[i] = wv[i][W_W-1];
            wmag_next[i] = wv[i][W_W-1] ? W_W'(-wv[i]) : W_W'(wv[i]);
        end
    end

    logic                    v2_vld;
    logic [ROOT_W-1:0]       v2_ms;
    logic [2:0][NORM_W-1:0]  v2_amag;
    logic [3*ARITH_W+2:0]    v2_side;

    esv_vlen #(
        .MAG_W  (W_W),
        .SIDE_W (3 * ARITH_W + 3),
        .S_W    (S2_W)
    ) u_vlen_flee (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (w_vld_reg),
        .mag       (w_mag_reg),
        .in_side   ({w_av_reg, w_neg_reg}),
        .out_valid (v2_vld),
        .s         (),
        .ms        (v2_ms),
        .amag      (v2_amag),
        .out_side  (v2_side)
    );

    // desired velocity at top speed
    logic                    sc1_vld;
    logic [2:0][ARITH_W-1:0] dw;
    logic [3*ARITH_W-1:0]    sc1_side;
    fix_t [2:0]              sc1_av;

    esv_scale #(
        .SIDE_W (3 * ARITH_W)
    ) u_scale_desired (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_vld),
        .amag      (v2_amag),
        .neg       (v2_side[2:0]),
        .ms        (v2_ms),
        .top_speed (top_speed_reg),
        .in_side   (v2_side[3*ARITH_W+2:3]),
        .out_valid (sc1_vld),
        .val       (dw),
        .out_side  (sc1_side)
    );

    assign sc1_av = sc1_side;

    // ---------------- blend by frame step ----------------
    logic signed [32:0]  diff [3];
    logic [32:0]         dfm  [3];
    logic [2:0][49:0]    f_p_reg;
    logic [2:0]          f_neg_reg;
    fix_t [2:0]          f_av_reg;
    logic                f_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = 33'($signed(dw[i])) - 33'($signed(sc1_av[i]));
            dfm[i]  = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
        end
    end

    logic [33:0]            mm2  [3];
    logic signed [NV_W-1:0] term2 [3];
    logic signed [NV_W-1:0] nv    [3];
    logic [2:0][NV_W-1:0]   nv_next;
    logic [2:0][NV_W-1:0]   nmag_next;
    logic [2:0][NV_W-1:0]   n_nv_reg;
    logic [2:0][NV_W-1:0]   n_mag_reg;
    logic                   n_vld_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mm2[i]   = f_p_reg[i][49:16];
            term2[i] = f_neg_reg[i] ? -$signed({2'b0, mm2[i]}) : $signed({2'b0, mm2[i]});
            nv[i]    = NV_W'($signed(f_av_reg[i])) + term2[i];
            nv_next[i]   = nv[i];
            nmag_next[i] = nv[i][NV_W-1] ? NV_W'(-nv[i]) : NV_W'(nv[i]);
        end
    end

    // ---------------- speed limit ----------------
    logic                    v3_vld;
    logic [S3_W-1:0]         v3_s;
    logic [ROOT_W-1:0]       v3_ms;
    logic [2:0][NORM_W-1:0]  v3_amag;
    logic [3*NV_W-1:0]       v3_side;

    esv_vlen #(
        .MAG_W  (NV_W),
        .SIDE_W (3 * NV_W),
        .S_W    (S3_W)
    ) u_vlen_new (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (n_vld_reg),
        .mag       (n_mag_reg),
        .in_side   (n_nv_reg),
        .out_valid (v3_vld),
        .s         (v3_s),
        .ms        (v3_ms),
        .amag      (v3_amag),
        .out_side  (v3_side)
    );

    logic [LEN3_W-1:0]       len3;
    logic                    over_next;
    logic                    l_over_reg;
    logic [2:0][NORM_W-1:0]  l_amag_reg;
    logic [ROOT_W-1:0]       l_ms_reg;
    logic [2:0][NV_W-1:0]    l_nv_reg;
    logic                    l_vld_reg;

    always_comb
    begin
        len3      = LEN3_W'(v3_ms) << v3_s;
        over_next = len3 > LEN3_W'(top_speed_reg);
    end

    logic                    sc2_vld;
    logic [2:0][ARITH_W-1:0] lim;
    logic [3*NV_W:0]         sc2_side;
    logic [2:0][NV_W-1:0]    sc2_nv;
    logic                    sc2_over;

    esv_scale #(
        .SIDE_W (3 * NV_W + 1)
    ) u_scale_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l_vld_reg),
        .amag      (l_amag_reg),
        .neg       ({l_nv_reg[2][NV_W-1], l_nv_reg[1][NV_W-1], l_nv_reg[0][NV_W-1]}),
        .ms        (l_ms_reg),
        .top_speed (top_speed_reg),
        .in_side   ({l_nv_reg, l_over_reg}),
        .out_valid (sc2_vld),
        .val       (lim),
        .out_side  (sc2_side)
    );

    assign sc2_nv   = sc2_side[3*NV_W:1];
    assign sc2_over = sc2_side[0];

    // ---------------- output select and saturation ----------------
    logic signed [NV_W-1:0]       res  [3];
    logic signed [63:0]           r64  [3];
    logic [2:0][COORD_WIDTH-1:0]  vel_next;
    logic [2:0][COORD_WIDTH-1:0]  out_vel_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            res[i] = sc2_over ? NV_W'($signed(lim[i])) : $signed(sc2_nv[i]);
            r64[i] = 64'(res[i]);
            if (r64[i] > OUT_HI)
                r64[i] = OUT_HI;
            else if (r64[i] < OUT_LO)
                r64[i] = OUT_LO;
            vel_next[i] = r64[i][COORD_WIDTH-1:0];
        end
    end

    // ---------------- top-level stage registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg    <= 1'b0;
            t_vld_reg     <= 1'b0;
            m_vld_reg     <= 1'b0;
            w_vld_reg     <= 1'b0;
            f_vld_reg     <= 1'b0;
            n_vld_reg     <= 1'b0;
            l_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg    <= in_valid;
            t_vld_reg     <= v1_vld;
            m_vld_reg     <= d1_vld;
            w_vld_reg     <= m_vld_reg;
            f_vld_reg     <= sc1_vld;
            n_vld_reg     <= f_vld_reg;
            l_vld_reg     <= v3_vld;
            out_valid_reg <= sc2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_kin_reg  <= kin_in;
            s0_dmag_reg <= dmag_next;

            t_dvd_reg   <= sat_next ? '0 : {len1, 16'b0};
            t_sat_reg   <= sat_next;
            t_kin_reg   <= v1_kin;

            for (int i = 0; i < 3; i++)
                m_p_reg[i] <= 64'(cvm[i]) * 64'(t_val);
            m_kin_reg   <= d1_kin;

            w_mag_reg   <= wmag_next;
            w_neg_reg   <= wneg_next;
            w_av_reg    <= m_kin_reg.av;

            for (int i = 0; i < 3; i++)
                f_p_reg[i] <= 50'(dfm[i]) * 50'(frame_step_reg);
            f_neg_reg   <= {diff[2][32], diff[1][32], diff[0][32]};
            f_av_reg    <= sc1_av;

            n_nv_reg    <= nv_next;
            n_mag_reg   <= nmag_next;

            l_over_reg  <= over_next;
            l_amag_reg  <= v3_amag;
            l_ms_reg    <= v3_ms;
            l_nv_reg    <= v3_side;

            out_vel_reg <= vel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_vel_x = out_vel_reg[0];
    assign new_vel_y = out_vel_reg[1];
    assign new_vel_z = out_vel_reg[2];

`ifndef NO_ASSERTIONS
    // input side only blocks while a result beat is waiting
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting result");

    // zero top speed must saturate the lookahead time
    a_zero_speed_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (t_vld_reg && top_speed_reg == '0) |-> t_sat_reg)
        else $error("lookahead not saturated at zero top speed");

    // speed limit only engages on a nonzero length
    a_limit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (l_vld_reg && l_over_reg) |-> (l_ms_reg != '0))
        else $error("speed limit with zero length");
`endif

endmodule

### verif/evade_steering_velocity_tb.sv
`timescale 1ns / 100ps

module evade_steering_velocity_tb;
    import esv_pkg::*;

    localparam int LATENCY = 212;

    typedef struct {
        logic signed [31:0] f [12];
    } agent_beat_t;

    typedef struct {
        logic signed [31:0] v [3];
    } vel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] in_f [12];
    logic out_valid;
    logic out_ready;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;

    agent_beat_t pending_agents[$];
    vel_t expected_vels[$];
    logic [63:0] pred_top_speed;
    logic [63:0] pred_frame_step;
    int mismatches;
    int checked;
    int accepted;
    int gap_left;
    int burst_left;
    int hold_left;
    bit long_hold_req;
    bit stim_done;

    evade_steering_velocity u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .chaser_pos_x(in_f[0]), .chaser_pos_y(in_f[1]), .chaser_pos_z(in_f[2]),
        .chaser_vel_x(in_f[3]), .chaser_vel_y(in_f[4]), .chaser_vel_z(in_f[5]),
        .agent_pos_x(in_f[6]), .agent_pos_y(in_f[7]), .agent_pos_z(in_f[8]),
        .agent_vel_x(in_f[9]), .agent_vel_y(in_f[10]), .agent_vel_z(in_f[11]),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_vel_x(new_vel_x), .new_vel_y(new_vel_y), .new_vel_z(new_vel_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] magn(logic signed [63:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic signed [63:0] with_sign(logic signed [63:0] r, logic [63:0] m);
        return r < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // returns full length; sh/ms get the prescale shift and shifted length
    function automatic logic [63:0] vec_length(logic signed [63:0] v [3], output int sh,
                                               output logic [63:0] ms);
        logic [63:0] m;
        logic [63:0] sum;
        logic [63:0] a;
        m = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
            if (magn(v[i]) > m)
                m = magn(v[i]);
        while ((m >> sh) >= (64'd1 << 31))
            sh++;
        for (int i = 0; i < 3; i++)
        begin
            a = magn(v[i]) >> sh;
            sum = sum + a * a;
        end
        ms = int_sqrt(sum);
        return ms << sh;
    endfunction

    function automatic logic signed [63:0] q16_mul(logic signed [63:0] a, logic [63:0] b);
        return with_sign(a, (magn(a) * b) >> 16);
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic vel_t predict_evade(agent_beat_t b);
        logic signed [63:0] cp [3], cv [3], ap [3], av [3], d [3], w [3], nv [3];
        logic [63:0] ln, t, ms;
        int sh;
        vel_t r;
        for (int i = 0; i < 3; i++)
        begin
            cp[i] = b.f[i];
            cv[i] = b.f[3+i];
            ap[i] = b.f[6+i];
            av[i] = b.f[9+i];
            d[i] = cp[i] - ap[i];
        end
        ln = vec_length(d, sh, ms);
        if (pred_top_speed == 0)
            t = 64'hFFFF_FFFF;
        else
        begin
            t = (ln << 16) / pred_top_speed;
            if (t > 64'hFFFF_FFFF)
                t = 64'hFFFF_FFFF;
        end
        for (int i = 0; i < 3; i++)
            w[i] = ap[i] - (cp[i] + q16_mul(cv[i], t));
        ln = vec_length(w, sh, ms);
        for (int i = 0; i < 3; i++)
            w[i] = (ms == 0) ? 64'sd0
                 : with_sign(w[i], ((magn(w[i]) >> sh) * pred_top_speed) / ms);
        for (int i = 0; i < 3; i++)
            nv[i] = av[i] + q16_mul(w[i] - av[i], pred_frame_step);
        ln = vec_length(nv, sh, ms);
        if (ln > pred_top_speed)
            for (int i = 0; i < 3; i++)
                nv[i] = ms ? with_sign(nv[i], ((magn(nv[i]) >> sh) * pred_top_speed) / ms)
                           : 64'sd0;
        for (int i = 0; i < 3; i++)
            r.v[i] = clamp32(nv[i]);
        return r;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    task automatic queue_agent(agent_beat_t b);
        pending_agents.push_back(b);
        expected_vels.push_back(predict_evade(b));
    endtask

    task automatic drain_and_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        while (pending_agents.size() != 0 || expected_vels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TOP_SPEED)
            pred_top_speed = val;
        else
            pred_frame_step = val & 17'h1FFFF;
    endtask

    task automatic random_phase(int n);
        agent_beat_t b;
        int mode;
        for (int k = 0; k < n; k++)
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 12; i++)
                b.f[i] = rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : mode);
            // occasionally put the chaser on top of the agent
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++)
                begin
                    b.f[i] = b.f[6+i];
                    b.f[3+i] = 0;
                end
            queue_agent(b);
        end
    endtask

    initial
    begin
        agent_beat_t b;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TOP_SPEED;
        cfg_data = '0;
        in_valid = 1'b0;
        for (int i = 0; i < 12; i++)
            in_f[i] = '0;
        out_ready = 1'b0;
        pred_top_speed = TOP_SPEED_RST;
        pred_frame_step = FRAME_STEP_RST;
        mismatches = 0;
        checked = 0;
        accepted = 0;
        long_hold_req = 0;
        stim_done = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zeros, extremes, coincident points, zero top speed later
        for (int i = 0; i < 12; i++) b.f[i] = 0;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = 32'h7FFF_FFFF;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = 32'h8000_0000;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = 32'hFFFF_FFFF;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = (i < 6) ? 32'h0001_0000 : 0;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = 0;
        b.f[9] = 32'h0010_0000;
        queue_agent(b);
        for (int i = 0; i < 12; i++) b.f[i] = 0;
        b.f[3] = 32'h0001_0000;
        b.f[8] = 32'h0004_0000;
        queue_agent(b);
        random_phase(11);

        // long receiver hold while the sender keeps offering
        long_hold_req = 1;
        random_phase(300);

        drain_and_write(REG_FRAME_STEP, 17'd65536);
        random_phase(150);
        drain_and_write(REG_TOP_SPEED, 31'h7FFF_FFFF);
        random_phase(150);
        drain_and_write(REG_FRAME_STEP, 17'd1);
        random_phase(100);
        drain_and_write(REG_TOP_SPEED, 31'd1);
        random_phase(100);
        drain_and_write(REG_TOP_SPEED, 31'd0);
        random_phase(20);
        drain_and_write(REG_FRAME_STEP, 17'h1FFFF);
        drain_and_write(REG_TOP_SPEED, 31'd3_276_800);
        random_phase(150);
        drain_and_write(REG_FRAME_STEP, 17'd32768);
        drain_and_write(REG_TOP_SPEED, 31'd65536);
        random_phase(150);
        stim_done = 1;
    end

    // sender: bursts and gaps; the beat on the bus is always the queue head
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                void'(pending_agents.pop_front());
                accepted <= accepted + 1;
            end
            if (in_valid && !in_ready)
                ;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_agents.size() != 0)
            begin
                in_valid <= 1'b1;
                for (int i = 0; i < 12; i++)
                    in_f[i] <= pending_agents[0].f[i];
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0)
                        gap_left <= $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: own stall pattern, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold_req && hold_left == 0 && accepted > 20 && accepted < 40)
        begin
            hold_left <= 600;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else
            out_ready <= ($urandom_range(0, 7) < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // check results beat by beat
    always @(posedge clk)
    begin
        vel_t want;
        logic signed [31:0] got [3];
        if (rst_n && out_valid && out_ready)
        begin
            got[0] = new_vel_x;
            got[1] = new_vel_y;
            got[2] = new_vel_z;
            if (expected_vels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %0d %0d %0d", got[0], got[1], got[2]);
            end
            else
            begin
                want = expected_vels.pop_front();
                checked++;
                for (int i = 0; i < 3; i++)
                    if (got[i] !== want.v[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("new_vel[%0d] mismatch beat %0d: exp %0d got %0d",
                                     i, checked, want.v[i], got[i]);
                    end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_vels.size() != 0 || pending_agents.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        $display("covered %0d agent beats over several speed/step settings incl. extremes",
                 checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout");
        $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
src/esv_pkg.sv
src/esv_isqrt.sv
src/esv_div.sv
src/esv_vlen.sv
src/esv_scale.sv
src/evade_steering_velocity.sv
verif/evade_steering_velocity_tb.sv
